// ===== design/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and helpers for the marching tetrahedra cell
// Payload structs, pipeline depths and the corner-class edge plan.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int unsigned CROSS_LAT  = 23;  // register stages in mtc_crossing
  localparam int unsigned EMIT_LAT   = 52;  // register stages in mtc_emit
  localparam int unsigned FIFO_DEPTH = 4;   // triangle queue entries

  // packed xyz, x in the low bits
  typedef logic [2:0][20:0] vec_t;
  typedef logic [2:0][25:0] ovec_t;
  typedef logic [2:0][15:0] nrm_t;

  typedef struct packed {
    logic [62:0]        corner_a_position;
    logic [62:0]        corner_b_position;
    logic [62:0]        corner_c_position;
    logic [62:0]        corner_d_position;
    logic signed [31:0] corner_a_value;
    logic signed [31:0] corner_b_value;
    logic signed [31:0] corner_c_value;
    logic signed [31:0] corner_d_value;
  } mtc_in_t;

  typedef struct packed {
    logic [62:0] vertex_first;
    logic [62:0] vertex_second;
    logic [62:0] vertex_third;
    logic [47:0] unit_normal;
    logic        last_triangle;
  } mtc_out_t;

  typedef struct packed {
    logic [2:0]       ni;
    logic [2:0]       no;
    logic [1:0]       ntri;
    logic [3:0][1:0]  ea;
    logic [3:0][1:0]  eb;
  } plan_t;

  // Edge endpoints for the four crossings. Triangle one is always X0,X1,X2;
  // a two-two split adds X0,X2,X3.
  function automatic plan_t mt_plan(input logic [3:0] solid);
    logic [3:0][1:0] ins;
    logic [3:0][1:0] outs;
    logic [2:0]      ni;
    logic [2:0]      no;
    plan_t           p;
    ins  = '0;
    outs = '0;
    ni   = '0;
    no   = '0;
    for (int i = 0; i < 4; i++) begin
      if (solid[i]) begin
        ins[ni[1:0]] = 2'(i);
        ni = ni + 3'd1;
      end else begin
        outs[no[1:0]] = 2'(i);
        no = no + 3'd1;
      end
    end
    p    = '0;
    p.ni = ni;
    p.no = no;
    case (ni)
      3'd1: begin
        p.ntri = 2'd1;
        p.ea   = {4{ins[0]}};
        p.eb   = {outs[0], outs[2], outs[1], outs[0]};
      end
      3'd3: begin
        p.ntri = 2'd1;
        p.ea   = {4{outs[0]}};
        p.eb   = {ins[0], ins[2], ins[1], ins[0]};
      end
      3'd2: begin
        p.ntri = 2'd2;
        p.ea   = {ins[1], ins[1], ins[0], ins[0]};
        p.eb   = {outs[0], outs[1], outs[1], outs[0]};
      end
      default: p.ntri = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/mtc_crossing.sv =====
// ----------------------------------------------------------------------------
// mtc_crossing: edge crossing point
// t = va/(va-vb) by a 17-step restoring divider, then lerp with rounding.
// ----------------------------------------------------------------------------
module mtc_crossing (
  input  logic          clk_i,
  input  logic          en_i,
  input  mtc_pkg::vec_t pa_i,
  input  logic [31:0]   va_i,
  input  mtc_pkg::vec_t pb_i,
  input  logic [31:0]   vb_i,
  output mtc_pkg::vec_t q_o
);
  import mtc_pkg::*;

  localparam int unsigned DivSteps = 17;

  typedef logic [2:0][21:0] dvec_t;
  typedef logic [2:0][39:0] pvec_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [16:0] quo;
    logic        lsb;
    logic [32:0] ad;
    logic        half;
    logic        zero;
    logic        sat;
    vec_t        pa;
    dvec_t       df;
  } div_t;

  logic [32:0] d1_d, d1_q;
  logic [31:0] va1_q;
  vec_t        pa1_q;
  dvec_t       df1_d, df1_q;

  logic        half2_q, zero2_q;
  logic [31:0] ava2_q;
  logic [32:0] ad2_q;
  vec_t        pa2_q;
  dvec_t       df2_q;

  div_t        dv0_d;
  div_t        dv_nx [DivSteps];
  div_t        dv_q  [DivSteps+1];
  logic [33:0] sh    [DivSteps];
  logic        ge    [DivSteps];

  logic [16:0] t_d, t_q;
  vec_t        pat_q;
  dvec_t       dft_q;
  pvec_t       pm_d, pm_q;
  vec_t        pam_q;
  logic [2:0][40:0] rs;
  vec_t        q_d, q_q;

  always_comb begin
    d1_d = {va_i[31], va_i} - {vb_i[31], vb_i};
    for (int k = 0; k < 3; k++) begin
      df1_d[k] = {pb_i[k][20], pb_i[k]} - {pa_i[k][20], pa_i[k]};
    end
  end

  always_comb begin
    dv0_d      = '0;
    dv0_d.sat  = ({2'b00, ava2_q} >= {ad2_q, 1'b0});
    dv0_d.rem  = {2'b00, ava2_q[31:1]};
    dv0_d.lsb  = ava2_q[0];
    dv0_d.ad   = ad2_q;
    dv0_d.half = half2_q;
    dv0_d.zero = zero2_q;
    dv0_d.pa   = pa2_q;
    dv0_d.df   = df2_q;
  end

  // one quotient bit per stage
  always_comb begin
    for (int j = 0; j < DivSteps; j++) begin
      dv_nx[j] = dv_q[j];
      sh[j]    = {dv_q[j].rem, (j == 0) ? dv_q[j].lsb : 1'b0};
      ge[j]    = (sh[j] >= {1'b0, dv_q[j].ad});
      dv_nx[j].rem = ge[j] ? 33'(sh[j] - {1'b0, dv_q[j].ad}) : sh[j][32:0];
      dv_nx[j].quo = {dv_q[j].quo[15:0], ge[j]};
    end
  end

  always_comb begin
    if (dv_q[DivSteps].half) begin
      t_d = 17'd32768;
    end else if (dv_q[DivSteps].zero) begin
      t_d = 17'd0;
    end else if (dv_q[DivSteps].sat || (dv_q[DivSteps].quo > 17'd65536)) begin
      t_d = 17'd65536;
    end else begin
      t_d = dv_q[DivSteps].quo;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pm_d[k] = $signed(dft_q[k]) * $signed({1'b0, t_q});
      rs[k]   = {pm_q[k][39], pm_q[k]} + 41'd32768;
      q_d[k]  = pam_q[k] + rs[k][36:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= d1_d;
      va1_q   <= va_i;
      pa1_q   <= pa_i;
      df1_q   <= df1_d;
      half2_q <= (d1_q == '0);
      zero2_q <= (va1_q == '0) || (va1_q[31] != d1_q[32]);
      ava2_q  <= va1_q[31] ? (~va1_q + 32'd1) : va1_q;
      ad2_q   <= d1_q[32] ? (~d1_q + 33'd1) : d1_q;
      pa2_q   <= pa1_q;
      df2_q   <= df1_q;
      dv_q[0] <= dv0_d;
      for (int j = 0; j < DivSteps; j++) begin
        dv_q[j+1] <= dv_nx[j];
      end
      t_q   <= t_d;
      pat_q <= dv_q[DivSteps].pa;
      dft_q <= dv_q[DivSteps].df;
      pm_q  <= pm_d;
      pam_q <= pat_q;
      q_q   <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== design/mtc_emit.sv =====
// ----------------------------------------------------------------------------
// mtc_emit: triangle normal and winding
// Cross product, scale, pipelined isqrt and divide, then orient.
// ----------------------------------------------------------------------------
module mtc_emit (
  input  logic           clk_i,
  input  logic           en_i,
  input  mtc_pkg::vec_t  a_i,
  input  mtc_pkg::vec_t  b_i,
  input  mtc_pkg::vec_t  c_i,
  input  mtc_pkg::ovec_t ow_i,
  output mtc_pkg::vec_t  a_o,
  output mtc_pkg::vec_t  b_o,
  output mtc_pkg::vec_t  c_o,
  output mtc_pkg::nrm_t  n_o,
  output logic           keep_o
);
  import mtc_pkg::*;

  localparam int unsigned SqrtSteps = 26;
  localparam int unsigned NdivSteps = 15;

  typedef logic [2:0][21:0] dvec_t;
  typedef logic [2:0][43:0] mvec_t;
  typedef logic [2:0][23:0] avec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  typedef struct packed {
    logic [49:0] x;
    logic [50:0] r;
    avec_t       am;
    logic [2:0]  sgn;
    logic        neg;
    logic        nz;
    tri_t        tr;
  } sq_t;

  typedef struct packed {
    logic [2:0][24:0] rem;
    logic [2:0][14:0] lo;
    logic [2:0][14:0] quo;
    logic [24:0]      len;
    logic [2:0]       sgn;
    logic             neg;
    logic             nz;
    tri_t             tr;
  } nd_t;

  tri_t  tr1_q, tr2_q, tr3_q, tr4_q, tr5_q, tr6_q, tr7_q, tr8_q;
  ovec_t ow1_q, ow2_q, ow3_q, ow4_q, ow5_q, ow6_q, ow7_q;
  dvec_t e1_d, e2_d, e1_q, e2_q;
  logic [5:0][43:0] pr_d, pr_q;
  logic [2:0][44:0] cr_d, cr_q;
  mvec_t mg_d, mg4_q, mg5_q, mg6_q;
  logic [2:0] sg4_q, sg5_q, sg6_q, sg7_q, sg8_q;
  logic nz4_q, nz5_q, nz6_q, nz7_q, nz8_q;
  logic [43:0] m_d, m5_q;
  logic [4:0]  s_d, s6_q;
  avec_t am_d, am7_q, am8_q;
  logic [2:0][24:0] ns_d, ns7_q;
  logic [2:0][47:0] sq_d, sq8_q;
  logic [2:0][50:0] dp_d, dp8_q;
  logic signed [52:0] dsum;

  sq_t  sq0_d;
  sq_t  sq_nx [SqrtSteps];
  sq_t  sq_q  [SqrtSteps+1];
  logic [50:0] bitv [SqrtSteps];
  logic [50:0] rb   [SqrtSteps];

  nd_t  nd0_d;
  logic [24:0] len_d;
  logic [2:0][38:0] num_d;
  nd_t  nd_nx [NdivSteps];
  nd_t  nd_q  [NdivSteps+1];
  logic [2:0][25:0] nsh [NdivSteps];
  logic [2:0]       nge [NdivSteps];

  logic [2:0][15:0] v_d;
  nrm_t n_d, n_q;
  vec_t a_q, b_q, c_q;
  logic keep_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = {b_i[k][20], b_i[k]} - {a_i[k][20], a_i[k]};
      e2_d[k] = {c_i[k][20], c_i[k]} - {a_i[k][20], a_i[k]};
    end
    pr_d[0] = $signed(e1_q[1]) * $signed(e2_q[2]);
    pr_d[1] = $signed(e1_q[2]) * $signed(e2_q[1]);
    pr_d[2] = $signed(e1_q[2]) * $signed(e2_q[0]);
    pr_d[3] = $signed(e1_q[0]) * $signed(e2_q[2]);
    pr_d[4] = $signed(e1_q[0]) * $signed(e2_q[1]);
    pr_d[5] = $signed(e1_q[1]) * $signed(e2_q[0]);
    for (int k = 0; k < 3; k++) begin
      cr_d[k] = {pr_q[2*k][43], pr_q[2*k]} - {pr_q[2*k+1][43], pr_q[2*k+1]};
      mg_d[k] = cr_q[k][44] ? 44'(~cr_q[k] + 45'd1) : cr_q[k][43:0];
    end
    m_d = (mg4_q[0] > mg4_q[1]) ? mg4_q[0] : mg4_q[1];
    m_d = (mg4_q[2] > m_d) ? mg4_q[2] : m_d;
    // smallest shift that brings the largest magnitude below 2^24
    s_d = '0;
    for (int i = 24; i < 44; i++) begin
      if (m5_q[i]) s_d = 5'(i - 23);
    end
    for (int k = 0; k < 3; k++) begin
      am_d[k] = 24'(mg6_q[k] >> s6_q);
      ns_d[k] = sg6_q[k] ? (~{1'b0, am_d[k]} + 25'd1) : {1'b0, am_d[k]};
      sq_d[k] = am7_q[k] * am7_q[k];
      dp_d[k] = $signed(ns7_q[k]) * $signed(ow7_q[k]);
    end
  end

  always_comb begin
    dsum = 53'($signed(dp8_q[0])) + 53'($signed(dp8_q[1])) + 53'($signed(dp8_q[2]));
    sq0_d     = '0;
    sq0_d.x   = 50'(sq8_q[0]) + 50'(sq8_q[1]) + 50'(sq8_q[2]);
    sq0_d.am  = am8_q;
    sq0_d.sgn = sg8_q;
    sq0_d.neg = dsum[52];
    sq0_d.nz  = nz8_q;
    sq0_d.tr  = tr8_q;
  end

  // integer square root, one result bit per stage
  always_comb begin
    for (int j = 0; j < SqrtSteps; j++) begin
      sq_nx[j] = sq_q[j];
      bitv[j]  = 51'd1 << (2 * (SqrtSteps - 1 - j));
      rb[j]    = sq_q[j].r + bitv[j];
      if ({1'b0, sq_q[j].x} >= rb[j]) begin
        sq_nx[j].x = 50'({1'b0, sq_q[j].x} - rb[j]);
        sq_nx[j].r = (sq_q[j].r >> 1) + bitv[j];
      end else begin
        sq_nx[j].r = sq_q[j].r >> 1;
      end
    end
  end

  always_comb begin
    len_d = (sq_q[SqrtSteps].r[24:0] == '0) ? 25'd1 : sq_q[SqrtSteps].r[24:0];
    nd0_d     = '0;
    nd0_d.len = len_d;
    nd0_d.sgn = sq_q[SqrtSteps].sgn;
    nd0_d.neg = sq_q[SqrtSteps].neg;
    nd0_d.nz  = sq_q[SqrtSteps].nz;
    nd0_d.tr  = sq_q[SqrtSteps].tr;
    for (int k = 0; k < 3; k++) begin
      num_d[k]     = {1'b0, sq_q[SqrtSteps].am[k], 14'd0} + 39'(len_d >> 1);
      nd0_d.rem[k] = 25'(num_d[k] >> 15);
      nd0_d.lo[k]  = num_d[k][14:0];
    end
  end

  // normal divide, one quotient bit per stage on all three components
  always_comb begin
    for (int j = 0; j < NdivSteps; j++) begin
      nd_nx[j] = nd_q[j];
      for (int k = 0; k < 3; k++) begin
        nsh[j][k] = {nd_q[j].rem[k], nd_q[j].lo[k][4'(NdivSteps - 1 - j)]};
        nge[j][k] = (nsh[j][k] >= {1'b0, nd_q[j].len});
        nd_nx[j].rem[k] = nge[j][k] ? 25'(nsh[j][k] - {1'b0, nd_q[j].len})
                                    : nsh[j][k][24:0];
        nd_nx[j].quo[k] = {nd_q[j].quo[k][13:0], nge[j][k]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_d[k] = {1'b0, nd_q[NdivSteps].quo[k]};
      n_d[k] = (nd_q[NdivSteps].sgn[k] ^ nd_q[NdivSteps].neg) ? (~v_d[k] + 16'd1) : v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tr1_q <= '{a: a_i, b: b_i, c: c_i};
      ow1_q <= ow_i;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      tr2_q <= tr1_q;  ow2_q <= ow1_q;  pr_q <= pr_d;
      tr3_q <= tr2_q;  ow3_q <= ow2_q;  cr_q <= cr_d;
      tr4_q <= tr3_q;  ow4_q <= ow3_q;  mg4_q <= mg_d;
      for (int k = 0; k < 3; k++) sg4_q[k] <= cr_q[k][44];
      nz4_q <= (cr_q != '0);
      tr5_q <= tr4_q;  ow5_q <= ow4_q;  mg5_q <= mg4_q;  sg5_q <= sg4_q;  nz5_q <= nz4_q;
      m5_q  <= m_d;
      tr6_q <= tr5_q;  ow6_q <= ow5_q;  mg6_q <= mg5_q;  sg6_q <= sg5_q;  nz6_q <= nz5_q;
      s6_q  <= s_d;
      tr7_q <= tr6_q;  ow7_q <= ow6_q;  sg7_q <= sg6_q;  nz7_q <= nz6_q;
      am7_q <= am_d;   ns7_q <= ns_d;
      tr8_q <= tr7_q;  sg8_q <= sg7_q;  nz8_q <= nz7_q;  am8_q <= am7_q;
      sq8_q <= sq_d;   dp8_q <= dp_d;
      sq_q[0] <= sq0_d;
      for (int j = 0; j < SqrtSteps; j++) sq_q[j+1] <= sq_nx[j];
      nd_q[0] <= nd0_d;
      for (int j = 0; j < NdivSteps; j++) nd_q[j+1] <= nd_nx[j];
      a_q    <= nd_q[NdivSteps].tr.a;
      b_q    <= nd_q[NdivSteps].neg ? nd_q[NdivSteps].tr.c : nd_q[NdivSteps].tr.b;
      c_q    <= nd_q[NdivSteps].neg ? nd_q[NdivSteps].tr.b : nd_q[NdivSteps].tr.c;
      n_q    <= n_d;
      keep_q <= nd_q[NdivSteps].nz;
    end
  end

  assign a_o    = a_q;
  assign b_o    = b_q;
  assign c_o    = c_q;
  assign n_o    = n_q;
  assign keep_o = keep_q;

endmodule

// ===== design/marching_tetrahedra_cell.sv =====
// ----------------------------------------------------------------------------
// marching_tetrahedra_cell: tetrahedron to surface triangles
// Throughput: one tetrahedron per cycle while the result queue has room and
//   each yields at most one triangle; a two-triangle tetrahedron sends both
//   of its triangles through the single output port.
// The rate is set by the output port draining the result queue.
// Reset clears valid bits and the queue only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module marching_tetrahedra_cell #(
  parameter int unsigned FifoDepth = mtc_pkg::FIFO_DEPTH  // power of two, >= 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mtc_pkg::mtc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtc_pkg::mtc_out_t out_data_o
);
  import mtc_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  typedef struct packed {
    logic  v;
    logic  two;
    ovec_t ow;
  } side1_t;

  typedef struct packed {
    logic v;
    logic two;
  } side2_t;

  // Whole pipeline advances on one enable. The enable looks only at the
  // registered queue fill, so there is no path from out_ready_i to in_ready_o.
  logic en;

  // stage 0: input register
  logic    v0_q;
  mtc_in_t in0_q;

  // stage 1: classify and route corners to the four crossing units
  vec_t        pos [4];
  logic [31:0] val [4];
  logic [3:0]  solid;
  plan_t       plan;
  logic [2:0][22:0] sin_d, sout_d;

  logic        v1_q, two1_q;
  logic [2:0]  ni1_q, no1_q;
  logic [2:0][22:0] sin1_q, sout1_q;
  vec_t        xpa_q [4];
  vec_t        xpb_q [4];
  logic [31:0] xva_q [4];
  logic [31:0] xvb_q [4];

  vec_t   xq [4];
  side1_t side1_d;
  side1_t side1_q [CROSS_LAT];
  side2_t side2_q [EMIT_LAT];
  logic signed [26:0] owa, owb;

  vec_t        ea_v, eb_v, ec_v, fa_v, fb_v, fc_v;
  nrm_t        en_v, fn_v;
  logic        ekeep, fkeep;

  // result queue
  mtc_out_t        fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            k1, k2, pop;
  logic [1:0]      push_n;
  mtc_out_t        tri_a, tri_b, slot0, slot1;

  assign en         = (cnt_q <= (PtrW+1)'(FifoDepth - 2));
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q && (plan.ntri != 2'd0);
    end
  end

  always_comb begin
    pos[0] = vec_t'(in0_q.corner_a_position);
    pos[1] = vec_t'(in0_q.corner_b_position);
    pos[2] = vec_t'(in0_q.corner_c_position);
    pos[3] = vec_t'(in0_q.corner_d_position);
    val[0] = in0_q.corner_a_value;
    val[1] = in0_q.corner_b_value;
    val[2] = in0_q.corner_c_value;
    val[3] = in0_q.corner_d_value;
    for (int i = 0; i < 4; i++) solid[i] = val[i][31];  // negative means solid
    plan = mt_plan(solid);
    // corner sums on each side, for the centroid direction
    sin_d  = '0;
    sout_d = '0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++) begin
        if (solid[i]) sin_d[k] = sin_d[k] + {{2{pos[i][k][20]}}, pos[i][k]};
        else          sout_d[k] = sout_d[k] + {{2{pos[i][k][20]}}, pos[i][k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in0_q   <= in_data_i;
      two1_q  <= (plan.ntri == 2'd2);
      ni1_q   <= plan.ni;
      no1_q   <= plan.no;
      sin1_q  <= sin_d;
      sout1_q <= sout_d;
      for (int e = 0; e < 4; e++) begin
        xpa_q[e] <= pos[plan.ea[e]];
        xva_q[e] <= val[plan.ea[e]];
        xpb_q[e] <= pos[plan.eb[e]];
        xvb_q[e] <= val[plan.eb[e]];
      end
    end
  end

  for (genvar e = 0; e < 4; e++) begin : g_cross
    mtc_crossing u_cross (
      .clk_i (clk_i),
      .en_i  (en),
      .pa_i  (xpa_q[e]),
      .va_i  (xva_q[e]),
      .pb_i  (xpb_q[e]),
      .vb_i  (xvb_q[e]),
      .q_o   (xq[e])
    );
  end

  // outward = nin * sum(free) - nout * sum(solid), no division
  always_comb begin
    side1_d     = '0;
    side1_d.v   = v1_q;
    side1_d.two = two1_q;
    for (int k = 0; k < 3; k++) begin
      owa = $signed({1'b0, ni1_q}) * $signed(sout1_q[k]);
      owb = $signed({1'b0, no1_q}) * $signed(sin1_q[k]);
      side1_d.ow[k] = 26'(owa - owb);
    end
  end

  // side data walks beside the crossing and emit pipelines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CROSS_LAT; i++) side1_q[i] <= '0;
      for (int i = 0; i < EMIT_LAT; i++)  side2_q[i] <= '0;
    end else if (en) begin
      side1_q[0] <= side1_d;
      for (int i = 1; i < CROSS_LAT; i++) side1_q[i] <= side1_q[i-1];
      side2_q[0] <= '{v: side1_q[CROSS_LAT-1].v, two: side1_q[CROSS_LAT-1].two};
      for (int i = 1; i < EMIT_LAT; i++) side2_q[i] <= side2_q[i-1];
    end
  end

  mtc_emit u_emit0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (xq[0]),
    .b_i    (xq[1]),
    .c_i    (xq[2]),
    .ow_i   (side1_q[CROSS_LAT-1].ow),
    .a_o    (ea_v),
    .b_o    (eb_v),
    .c_o    (ec_v),
    .n_o    (en_v),
    .keep_o (ekeep)
  );

  mtc_emit u_emit1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (xq[0]),
    .b_i    (xq[2]),
    .c_i    (xq[3]),
    .ow_i   (side1_q[CROSS_LAT-1].ow),
    .a_o    (fa_v),
    .b_o    (fb_v),
    .c_o    (fc_v),
    .n_o    (fn_v),
    .keep_o (fkeep)
  );

  // Push kept triangles; the last one pushed for an item carries the flag.
  always_comb begin
    k1 = side2_q[EMIT_LAT-1].v && ekeep;
    k2 = side2_q[EMIT_LAT-1].v && side2_q[EMIT_LAT-1].two && fkeep;
    tri_a = '{vertex_first: ea_v, vertex_second: eb_v, vertex_third: ec_v,
              unit_normal: en_v, last_triangle: 1'b1};
    tri_b = '{vertex_first: fa_v, vertex_second: fb_v, vertex_third: fc_v,
              unit_normal: fn_v, last_triangle: 1'b1};
    slot0 = k1 ? tri_a : tri_b;
    slot0.last_triangle = !(k1 && k2);
    slot1 = tri_b;
    push_n = en ? ({1'b0, k1} + {1'b0, k2}) : 2'd0;
    pop    = out_valid_o && out_ready_i;
    cnt_d  = cnt_q + (PtrW+1)'(push_n) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_q] <= slot0;
    if (push_n == 2'd2) fifo_q[wr_q + PtrW'(1)] <= slot1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_q];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(FifoDepth))
    else $error("result queue overflow");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (cnt_q <= (PtrW+1)'(FifoDepth - 2)))
    else $error("two-triangle push without room");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(side2_q[EMIT_LAT-1]))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== bench/mtc_checker.sv =====
// ----------------------------------------------------------------------------
// mtc_checker: triangle predictor and scoreboard for the cell
// Watches both channels, predicts triangles per tetrahedron, compares in order.
// ----------------------------------------------------------------------------
module mtc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  mtc_pkg::mtc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  mtc_pkg::mtc_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  mtc_pkg::mtc_out_t tri_q[$];
  int unsigned       fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = tri_q.size();

  function automatic longint sx21(logic [20:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic void unpack_pos(input logic [62:0] w, output vec3_t p);
    for (int k = 0; k < 3; k++) p[k] = sx21(w[21*k +: 21]);
  endfunction

  function automatic logic [62:0] pack_pos(input vec3_t p);
    logic [62:0] w;
    for (int k = 0; k < 3; k++) w[21*k +: 21] = p[k][20:0];
    return w;
  endfunction

  // round to nearest of p/65536, halves up
  function automatic longint rnd16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic void cross_edge(input vec3_t pa, input longint va,
                                     input vec3_t pb, input longint vb,
                                     output vec3_t r);
    longint d, t, q;
    d = va - vb;
    if (d == 0) t = 32768;
    else if (va == 0 || ((va < 0) != (d < 0))) t = 0;
    else begin
      q = ((va < 0 ? -va : va) << 16) / (d < 0 ? -d : d);
      t = q > 65536 ? 65536 : q;
    end
    for (int k = 0; k < 3; k++) r[k] = pa[k] + rnd16((pb[k] - pa[k]) * t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // builds one triangle; returns 0 when degenerate
  function automatic bit make_tri(input vec3_t a, input vec3_t b, input vec3_t c,
                                  input vec3_t outward,
                                  output mtc_pkg::mtc_out_t t);
    longint e1[3], e2[3], cr[3], ns[3], nq[3], dot, v;
    longint unsigned m, am, sum, len;
    int s;
    e1 = '{b[0]-a[0], b[1]-a[1], b[2]-a[2]};
    e2 = '{c[0]-a[0], c[1]-a[1], c[2]-a[2]};
    cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
    cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
    cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
    t = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) return 0;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      am = cr[k] < 0 ? -cr[k] : cr[k];
      if (am > m) m = am;
    end
    s = 0;
    while ((m >> s) >= (64'd1 << 24)) s++;
    sum = 0;
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      am = (cr[k] < 0 ? -cr[k] : cr[k]) >> s;
      ns[k] = cr[k] < 0 ? -longint'(am) : longint'(am);
      sum += am * am;
      dot += ns[k] * outward[k];
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int k = 0; k < 3; k++) begin
      v = longint'(((ns[k] < 0 ? -ns[k] : ns[k]) * 16384 + len / 2) / len);
      nq[k] = ns[k] < 0 ? -v : v;
    end
    t.vertex_first = pack_pos(a);
    if (dot < 0) begin
      t.vertex_second = pack_pos(c);
      t.vertex_third  = pack_pos(b);
      for (int k = 0; k < 3; k++) nq[k] = -nq[k];
    end else begin
      t.vertex_second = pack_pos(b);
      t.vertex_third  = pack_pos(c);
    end
    for (int k = 0; k < 3; k++) t.unit_normal[16*k +: 16] = nq[k][15:0];
    return 1;
  endfunction

  task automatic predict_triangles(input mtc_pkg::mtc_in_t it);
    vec3_t p[4], sin, sout, outward, q0, q1, q2, q3;
    longint v[4];
    int ins[4], outs[4], ni, no, n, lone;
    mtc_pkg::mtc_out_t t[2];
    mtc_pkg::mtc_out_t tt;
    unpack_pos(it.corner_a_position, p[0]);
    unpack_pos(it.corner_b_position, p[1]);
    unpack_pos(it.corner_c_position, p[2]);
    unpack_pos(it.corner_d_position, p[3]);
    v[0] = it.corner_a_value;
    v[1] = it.corner_b_value;
    v[2] = it.corner_c_value;
    v[3] = it.corner_d_value;
    ni = 0;
    no = 0;
    for (int i = 0; i < 4; i++)
      if (v[i] < 0) ins[ni++] = i; else outs[no++] = i;
    if (ni == 0 || no == 0) return;
    for (int k = 0; k < 3; k++) begin
      sin[k] = 0;
      sout[k] = 0;
      for (int i = 0; i < ni; i++) sin[k] += p[ins[i]][k];
      for (int i = 0; i < no; i++) sout[k] += p[outs[i]][k];
      outward[k] = ni * sout[k] - no * sin[k];
    end
    n = 0;
    if (ni == 1 || no == 1) begin
      lone = ni == 1 ? ins[0] : outs[0];
      if (ni == 1) begin
        cross_edge(p[lone], v[lone], p[outs[0]], v[outs[0]], q0);
        cross_edge(p[lone], v[lone], p[outs[1]], v[outs[1]], q1);
        cross_edge(p[lone], v[lone], p[outs[2]], v[outs[2]], q2);
      end else begin
        cross_edge(p[lone], v[lone], p[ins[0]], v[ins[0]], q0);
        cross_edge(p[lone], v[lone], p[ins[1]], v[ins[1]], q1);
        cross_edge(p[lone], v[lone], p[ins[2]], v[ins[2]], q2);
      end
      if (make_tri(q0, q1, q2, outward, tt)) t[n++] = tt;
    end else begin
      cross_edge(p[ins[0]], v[ins[0]], p[outs[0]], v[outs[0]], q0);
      cross_edge(p[ins[0]], v[ins[0]], p[outs[1]], v[outs[1]], q1);
      cross_edge(p[ins[1]], v[ins[1]], p[outs[1]], v[outs[1]], q2);
      cross_edge(p[ins[1]], v[ins[1]], p[outs[0]], v[outs[0]], q3);
      if (make_tri(q0, q1, q2, outward, tt)) t[n++] = tt;
      if (make_tri(q0, q2, q3, outward, tt)) t[n++] = tt;
    end
    if (n > 0) t[n-1].last_triangle = 1'b1;
    for (int i = 0; i < n; i++) tri_q.insert(tri_q.size(), t[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    mtc_pkg::mtc_out_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_triangles(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (tri_q.size() == 0)
          report_mismatch("unexpected triangle", 64'(out_data_i.vertex_first), 64'd0);
        else begin
          w = tri_q.pop_front();
          if (out_data_i.vertex_first !== w.vertex_first)
            report_mismatch("vertex_first", 64'(out_data_i.vertex_first),
                            64'(w.vertex_first));
          if (out_data_i.vertex_second !== w.vertex_second)
            report_mismatch("vertex_second", 64'(out_data_i.vertex_second),
                            64'(w.vertex_second));
          if (out_data_i.vertex_third !== w.vertex_third)
            report_mismatch("vertex_third", 64'(out_data_i.vertex_third),
                            64'(w.vertex_third));
          if (out_data_i.unit_normal !== w.unit_normal)
            report_mismatch("unit_normal", 64'(out_data_i.unit_normal),
                            64'(w.unit_normal));
          if (out_data_i.last_triangle !== w.last_triangle)
            report_mismatch("last_triangle", 64'(out_data_i.last_triangle),
                            64'(w.last_triangle));
        end
      end
    end
  end
endmodule

// ===== bench/marching_tetrahedra_cell_tb.sv =====
// ----------------------------------------------------------------------------
// marching_tetrahedra_cell_tb: stimulus and verdict for the tetrahedron cell
// Directed corner cases, then random tetrahedra under four idling phases;
// the checker beside the block predicts and compares every triangle.
// ----------------------------------------------------------------------------
module marching_tetrahedra_cell_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 200;  // above the cell's input-to-output latency

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  mtc_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  mtc_out_t    out_data;
  int unsigned fail_count;
  int unsigned pending;

  // idle percentages, one for the sender and one for the receiver process
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  marching_tetrahedra_cell u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  mtc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // random coordinate: mostly small so normals stay well formed,
  // sometimes the full 21-bit range to exercise every bit
  function automatic logic [20:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 21'($urandom);
      1:       return $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
      default: return 21'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [62:0] rand_pos();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [31:0] rand_dist(bit solid);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = $urandom;
      1:       v = 32'($urandom_range(0, 3));
      default: v = 32'($urandom_range(1, 200000));
    endcase
    // force the sign so the corner class is what the caller wants
    if (solid) return (v[31] ? v : (v == 0 ? 32'hFFFF_FFFF : -v));
    return v[31] ? (v == 32'h8000_0000 ? 32'h7FFF_FFFF : -v) : v;
  endfunction

  function automatic mtc_in_t rand_tet();
    mtc_in_t t;
    logic [3:0] solid;
    solid = 4'($urandom);
    t.corner_a_position = rand_pos();
    t.corner_b_position = rand_pos();
    t.corner_c_position = rand_pos();
    t.corner_d_position = rand_pos();
    t.corner_a_value = rand_dist(solid[0]);
    t.corner_b_value = rand_dist(solid[1]);
    t.corner_c_value = rand_dist(solid[2]);
    t.corner_d_value = rand_dist(solid[3]);
    // a little pure noise with unconstrained fields
    if ($urandom_range(0, 19) == 0)
      t = mtc_in_t'($bits(mtc_in_t)'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom}));
    return t;
  endfunction

  // one transfer on the input channel; valid stays up across back-to-back items
  task automatic send_tet(input mtc_in_t t);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic mtc_in_t unit_tet(logic [31:0] va, logic [31:0] vb,
                                       logic [31:0] vc, logic [31:0] vd);
    mtc_in_t t;
    t.corner_a_position = {21'd0, 21'd0, 21'd0};
    t.corner_b_position = {21'd0, 21'd0, 21'd1024};
    t.corner_c_position = {21'd0, 21'd1024, 21'd0};
    t.corner_d_position = {21'd1024, 21'd0, 21'd0};
    t.corner_a_value = va;
    t.corner_b_value = vb;
    t.corner_c_value = vc;
    t.corner_d_value = vd;
    return t;
  endfunction

  localparam logic [31:0] NEG = 32'hFFFF_0000;  // -1.0
  localparam logic [31:0] POS = 32'h0001_0000;  // +1.0

  // receiver: stalls at the current phase's rate
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    mtc_in_t t;
    in_valid       = 1'b0;
    in_data        = '0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every corner class, equal distances, zero distance,
    // extreme distances, degenerate (flat) tetrahedron, extreme coordinates
    for (int m = 0; m < 16; m++)
      send_tet(unit_tet(m[0] ? NEG : POS, m[1] ? NEG : POS,
                        m[2] ? NEG : POS, m[3] ? NEG : POS));
    send_tet(unit_tet(NEG, NEG, 32'd0, POS));
    send_tet(unit_tet(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_tet(unit_tet(32'h8000_0000, 32'd0, 32'd0, 32'd0));
    send_tet(unit_tet(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
    t = unit_tet(NEG, POS, POS, POS);
    t.corner_b_position = t.corner_a_position;  // zero-area triangle dropped
    t.corner_c_position = t.corner_a_position;
    t.corner_d_position = t.corner_a_position;
    send_tet(t);
    t = unit_tet(NEG, POS, NEG, POS);
    t.corner_a_position = {3{21'h100000}};
    t.corner_b_position = {3{21'h0FFFFF}};
    t.corner_c_position = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
    t.corner_d_position = {21'h100000, 21'h0FFFFF, 21'h0FFFFF};
    send_tet(t);

    // hold off until every expected triangle has arrived
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < 360; i++) send_tet(rand_tet());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
